// File: hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int TableDepth = 1024;
   localparam int AddrW      = $clog2(TableDepth);
   localparam int CountW     = $clog2(TableDepth + 1);

   localparam logic [2:0] ST_INTERIOR  = 3'd0;
   localparam logic [2:0] ST_CLAMP_LO  = 3'd1;
   localparam logic [2:0] ST_CLAMP_HI  = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_NO_BRACK  = 3'd4;
   localparam logic [2:0] ST_LOADED    = 3'd5;
   localparam logic [2:0] ST_FULL      = 3'd6;

   // controller -> datapath
   typedef struct packed {
      logic             capture;   // latch request word
      logic             store;     // write point at count
      logic             rd_en;     // issue a memory read
      logic [AddrW-1:0] rd_addr;
      logic             grab_a;    // registered read data -> lower point
      logic             grab_b;    // registered read data -> upper point
      logic             div_start;
      logic             set_out;   // load output register
      logic [2:0]       out_status;
      logic [1:0]       out_sel;   // 0 zero, 1 point a, 2 lerp
   } ctrl_type;

   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_A    = 2'd1;
   localparam logic [1:0] SEL_LERP = 2'd2;

   // datapath -> controller
   typedef struct packed {
      logic is_query;
      logic le_a;       // key <= time in read data
      logic ge_a;       // key >= time of point a
      logic le_b;       // key <= time in read data
      logic ge_rd;      // key >= time in read data
      logic eq_ab;      // zero-width interval
      logic div_done;
   } stat_type;

endpackage

// File: hw/rtl/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit
// Table of time/altitude/accel points with clamped linear interpolation.
// ----------------------------------------------------------------------------
// Loads and empty queries answer from decode; clamp low follows the read of
// point 0, clamp high that of the last point. The walk tests one pair per cycle
// off the single registered read port up to the bracket (or the last point),
// then, unless the pair is zero-width, two 64-step restoring dividers run side
// by side. Throughput: one word at a time; the next request is taken the cycle
// after the result word is delivered. Reset clears count.
module piecewise_linear_interpolator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [31:0]        req_point_time,
   input  logic signed [31:0] req_point_altitude,
   input  logic signed [31:0] req_point_accel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_altitude_out,
   output logic signed [31:0] rsp_accel_out,
   output logic [2:0]         rsp_status
);
   import pli_pkg::*;

   ctrl_type          ctrl;
   stat_type          stat;
   logic [CountW-1:0] count;

   // sequencer: owns handshakes and the entry count
   pli_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .ctrl, .count
   );

   // memories, bracket registers, dividers and result word register
   pli_datapath u_dp (
      .clock, .reset, .ctrl, .req_cmd, .req_point_time, .req_point_altitude,
      .req_point_accel, .count, .stat, .rsp_altitude_out, .rsp_accel_out,
      .rsp_status
   );
endmodule

// File: hw/rtl/pli_divider.sv
// ----------------------------------------------------------------------------
// pli_divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pli_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;
   logic [32:0] sh;

   assign sh    = {r_ff[31:0], q_ff[63]};
   assign trial = sh - {1'b0, divisor};

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done     = busy_ff && (cnt_ff == 7'd63);
   assign quotient = q_in;
endmodule

// File: hw/rtl/pli_datapath.sv
// ----------------------------------------------------------------------------
// pli_datapath
// Point memories, bracket registers, two lerp dividers and result register.
// ----------------------------------------------------------------------------
module pli_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pli_pkg::ctrl_type    ctrl,
   input  logic                 req_cmd,
   input  logic [31:0]          req_point_time,
   input  logic signed [31:0]   req_point_altitude,
   input  logic signed [31:0]   req_point_accel,
   input  logic [pli_pkg::CountW-1:0] count,
   output pli_pkg::stat_type    stat,
   output logic signed [31:0]   rsp_altitude_out,
   output logic signed [31:0]   rsp_accel_out,
   output logic [2:0]           rsp_status
);
   import pli_pkg::*;

   logic [31:0] tmem [TableDepth];
   logic [31:0] amem [TableDepth];
   logic [31:0] cmem [TableDepth];

   logic        cmd_ff;
   logic [31:0] key_ff, wa_ff, wc_ff;
   logic [31:0] rt_ff, ra_ff, rc_ff;
   logic [31:0] ta_ff, aa_ff, ca_ff, tb_ff, ab_ff, cb_ff;
   logic        na_ff, nc_ff;
   logic [63:0] qa, qc;
   logic        dda, ddc, dsa_ff, dsc_ff;
   logic [63:0] da_ff, dc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_cmd;
         key_ff <= req_point_time;
         wa_ff  <= req_point_altitude;
         wc_ff  <= req_point_accel;
      end
      if (ctrl.store) begin
         tmem[count[AddrW-1:0]] <= key_ff;
         amem[count[AddrW-1:0]] <= wa_ff;
         cmem[count[AddrW-1:0]] <= wc_ff;
      end
      if (ctrl.rd_en) begin
         rt_ff <= tmem[ctrl.rd_addr];
         ra_ff <= amem[ctrl.rd_addr];
         rc_ff <= cmem[ctrl.rd_addr];
      end
      if (ctrl.grab_a) begin
         ta_ff <= rt_ff; aa_ff <= ra_ff; ca_ff <= rc_ff;
      end
      if (ctrl.grab_b) begin
         tb_ff <= rt_ff; ab_ff <= ra_ff; cb_ff <= rc_ff;
      end
   end

   // magnitude products, one register stage before the dividers
   logic signed [32:0] dya, dyc;
   logic [32:0] ma, mc;
   logic [31:0] dk, dx;
   assign dya = {ab_ff[31], ab_ff} - {aa_ff[31], aa_ff};
   assign dyc = {cb_ff[31], cb_ff} - {ca_ff[31], ca_ff};
   assign ma  = dya[32] ? -dya : dya;
   assign mc  = dyc[32] ? -dyc : dyc;
   assign dk  = key_ff - ta_ff;
   assign dx  = tb_ff - ta_ff;

   logic go_ff;
   always_ff @(posedge clock) begin
      if (ctrl.div_start) begin
         da_ff <= 64'(ma * {1'b0, dk});
         dc_ff <= 64'(mc * {1'b0, dk});
         na_ff <= dya[32];
         nc_ff <= dyc[32];
      end
      if (reset) go_ff <= 1'b0;
      else       go_ff <= ctrl.div_start;
   end

   pli_divider u_div_a (.clock, .reset, .start(go_ff), .dividend(da_ff), .divisor(dx),
                        .done(dda), .quotient(qa));
   pli_divider u_div_c (.clock, .reset, .start(go_ff), .dividend(dc_ff), .divisor(dx),
                        .done(ddc), .quotient(qc));

   always_ff @(posedge clock) begin
      if (reset) begin
         dsa_ff <= 1'b0;
         dsc_ff <= 1'b0;
      end else begin
         dsa_ff <= dda;
         dsc_ff <= ddc;
      end
   end

   logic [31:0] lq_a_ff, lq_c_ff;
   always_ff @(posedge clock) begin
      if (dda) lq_a_ff <= qa[31:0];
      if (ddc) lq_c_ff <= qc[31:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.set_out) begin
         rsp_status <= ctrl.out_status;
         case (ctrl.out_sel)
            SEL_A: begin
               rsp_altitude_out <= aa_ff;
               rsp_accel_out    <= ca_ff;
            end
            SEL_LERP: begin
               rsp_altitude_out <= na_ff ? aa_ff - lq_a_ff : aa_ff + lq_a_ff;
               rsp_accel_out    <= nc_ff ? ca_ff - lq_c_ff : ca_ff + lq_c_ff;
            end
            default: begin
               rsp_altitude_out <= '0;
               rsp_accel_out    <= '0;
            end
         endcase
      end
   end

   assign stat.is_query = cmd_ff;
   assign stat.le_a     = key_ff <= rt_ff;
   assign stat.ge_a     = key_ff >= ta_ff;
   assign stat.le_b     = key_ff <= rt_ff;
   assign stat.ge_rd    = key_ff >= rt_ff;
   assign stat.eq_ab    = tb_ff == ta_ff;
   assign stat.div_done = dsa_ff & dsc_ff;
endmodule

// File: hw/rtl/pli_controller.sv
// ----------------------------------------------------------------------------
// pli_controller
// Sequencer: load, clamp tests, linear bracket search, divide, respond.
// ----------------------------------------------------------------------------
module pli_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pli_pkg::stat_type    stat,
   output pli_pkg::ctrl_type    ctrl,
   output logic [pli_pkg::CountW-1:0] count
);
   import pli_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_RD0   = 4'd2;
   localparam logic [3:0] S_LO    = 4'd3;
   localparam logic [3:0] S_HI    = 4'd4;
   localparam logic [3:0] S_WALK  = 4'd5;
   localparam logic [3:0] S_CHK   = 4'd6;
   localparam logic [3:0] S_PEQ   = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;
   localparam logic [3:0] S_WAITA = 4'd10;

   logic [3:0]        st_ff, st_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [CountW-1:0] idx_ff, idx_in;   // index of upper point under test
   logic              vld_ff, vld_in;

   logic [CountW-1:0] last;
   assign last = cnt_ff - CountW'(1);

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      vld_in = vld_ff;
      ctrl   = '0;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && !vld_ff) begin
               ctrl.capture = 1'b1;
               st_in = S_DEC;
            end
         end
         S_DEC: begin
            if (!stat.is_query) begin
               ctrl.set_out = 1'b1;
               ctrl.out_sel = SEL_ZERO;
               if (cnt_ff < CountW'(TableDepth)) begin
                  ctrl.store = 1'b1;
                  cnt_in = cnt_ff + CountW'(1);
                  ctrl.out_status = ST_LOADED;
               end else begin
                  ctrl.out_status = ST_FULL;
               end
               st_in = S_RESP;
            end else if (cnt_ff == '0) begin
               ctrl.set_out = 1'b1;
               ctrl.out_sel = SEL_ZERO;
               ctrl.out_status = ST_EMPTY;
               st_in = S_RESP;
            end else begin
               ctrl.rd_en = 1'b1;
               ctrl.rd_addr = '0;
               st_in = S_RD0;
            end
         end
         S_RD0: begin
            ctrl.grab_a = 1'b1;
            if (stat.le_a) begin
               st_in = S_LO;
            end else begin
               ctrl.rd_en = 1'b1;
               ctrl.rd_addr = last[AddrW-1:0];
               st_in = S_HI;
            end
         end
         S_LO: begin
            ctrl.set_out = 1'b1;
            ctrl.out_sel = SEL_A;
            ctrl.out_status = ST_CLAMP_LO;
            st_in = S_RESP;
         end
         S_HI: begin
            if (stat.ge_rd || (cnt_ff == CountW'(1))) begin
               // key >= last time
               ctrl.grab_a = 1'b1;
               st_in = S_PEQ;
               idx_in = '0;
            end else begin
               ctrl.rd_en = 1'b1;
               ctrl.rd_addr = '0;
               idx_in = CountW'(1);
               st_in = S_WALK;
            end
         end
         S_PEQ: begin
            ctrl.set_out = 1'b1;
            ctrl.out_sel = SEL_A;
            ctrl.out_status = ST_CLAMP_HI;
            st_in = S_RESP;
         end
         S_WALK: begin
            // read data holds point idx-1: make it lower point, fetch idx
            ctrl.grab_a = 1'b1;
            ctrl.rd_en = 1'b1;
            ctrl.rd_addr = idx_ff[AddrW-1:0];
            st_in = S_CHK;
         end
         S_CHK: begin
            ctrl.grab_b = 1'b1;
            if (stat.ge_a && stat.le_b) begin
               st_in = S_WAITA;
            end else if (idx_ff == last) begin
               ctrl.set_out = 1'b1;
               ctrl.out_sel = SEL_ZERO;
               ctrl.out_status = ST_NO_BRACK;
               st_in = S_RESP;
            end else begin
               // current upper becomes next lower; fetch next upper
               ctrl.grab_a = 1'b1;
               idx_in = idx_ff + CountW'(1);
               ctrl.rd_en = 1'b1;
               ctrl.rd_addr = idx_in[AddrW-1:0];
            end
         end
         S_WAITA: begin
            if (stat.eq_ab) begin
               ctrl.set_out = 1'b1;
               ctrl.out_sel = SEL_A;
               ctrl.out_status = ST_INTERIOR;
               st_in = S_RESP;
            end else begin
               ctrl.div_start = 1'b1;
               st_in = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               ctrl.set_out = 1'b1;
               ctrl.out_sel = SEL_LERP;
               ctrl.out_status = ST_INTERIOR;
               st_in = S_RESP;
            end
         end
         S_RESP: begin
            vld_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   assign req_ready = (st_ff == S_IDLE) && !vld_ff;
   assign rsp_valid = vld_ff;
   assign count     = cnt_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CountW'(TableDepth)) else $error("entry count overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |-> (cnt_ff == $past(cnt_ff) + CountW'(1)))
      else $error("entry count moved by more than one");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("accept while result pending");
endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise linear interpolator: loads tables,
// queries them, and compares every result word against an internal predictor.
// ----------------------------------------------------------------------------
module tb;
   import pli_pkg::*;

   typedef struct packed {
      logic        cmd;
      logic [31:0] key;
      logic [31:0] alt;
      logic [31:0] acc;
   } req_word_type;

   typedef struct packed {
      logic [31:0] alt;
      logic [31:0] acc;
      logic [2:0]  status;
   } rsp_word_type;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
   localparam int   CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = 1'b0;
   logic [31:0] req_point_time = '0;
   logic signed [31:0] req_point_altitude = '0;
   logic signed [31:0] req_point_accel = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_altitude_out;
   logic signed [31:0] rsp_accel_out;
   logic [2:0] rsp_status;

   piecewise_linear_interpolator_unit i_dut (.*);

   // predictor state
   logic [31:0] tbl_time [TableDepth];
   logic [31:0] tbl_alt  [TableDepth];
   logic [31:0] tbl_acc  [TableDepth];
   int          tbl_count;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int  errors = 0;
   int  cycles = 0;
   int  n_sent = 0, n_checked = 0, n_interior = 0;
   bit  hold_sender = 0;
   bit  calm = 0;       // no idling in the last part of the run
   int  req_gap = 0, rsp_gap = 0;

   // Sampled handshake from the rising edge, consumed by the driver.
   logic req_ready_q = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // y0 + (y1-y0)*dk/dx, quotient truncated toward zero
   function automatic logic [31:0] lerp_value(logic [31:0] y0, logic [31:0] y1,
                                              logic [31:0] dk, logic [31:0] dx);
      logic signed [33:0] dy;
      logic [63:0] mag, q;
      logic signed [33:0] r;
      dy  = $signed({{2{y1[31]}}, y1}) - $signed({{2{y0[31]}}, y0});
      mag = dy < 0 ? 64'(-dy) : 64'(dy);
      q   = (mag * {32'd0, dk}) / {32'd0, dx};
      r   = dy < 0 ? $signed({{2{y0[31]}}, y0}) - $signed(34'(q))
                   : $signed({{2{y0[31]}}, y0}) + $signed(34'(q));
      return r[31:0];
   endfunction

   function automatic rsp_word_type interpolate_step(req_word_type w);
      rsp_word_type r;
      r = '0;
      if (w.cmd == CMD_LOAD) begin
         if (tbl_count < TableDepth) begin
            tbl_time[tbl_count] = w.key;
            tbl_alt[tbl_count]  = w.alt;
            tbl_acc[tbl_count]  = w.acc;
            tbl_count++;
            r.status = ST_LOADED;
         end else begin
            r.status = ST_FULL;
         end
      end else if (tbl_count == 0) begin
         r.status = ST_EMPTY;
      end else if (w.key <= tbl_time[0]) begin
         r = '{tbl_alt[0], tbl_acc[0], ST_CLAMP_LO};
      end else if (w.key >= tbl_time[tbl_count-1]) begin
         r = '{tbl_alt[tbl_count-1], tbl_acc[tbl_count-1], ST_CLAMP_HI};
      end else begin
         r.status = ST_NO_BRACK;
         for (int i = 0; i + 1 < tbl_count; i++) begin
            if (w.key >= tbl_time[i] && w.key <= tbl_time[i+1]) begin
               if (tbl_time[i] == tbl_time[i+1]) begin
                  r.alt = tbl_alt[i];
                  r.acc = tbl_acc[i];
               end else begin
                  r.alt = lerp_value(tbl_alt[i], tbl_alt[i+1], w.key - tbl_time[i],
                                     tbl_time[i+1] - tbl_time[i]);
                  r.acc = lerp_value(tbl_acc[i], tbl_acc[i+1], w.key - tbl_time[i],
                                     tbl_time[i+1] - tbl_time[i]);
               end
               r.status = ST_INTERIOR;
               break;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] rnd32();
      return $urandom();
   endfunction

   task automatic push_load(logic [31:0] t, logic [31:0] a, logic [31:0] c);
      pending_words.push_back('{CMD_LOAD, t, a, c});
   endtask

   task automatic push_query(logic [31:0] t);
      // altitude/accel fields are don't-care for queries: randomize them
      pending_words.push_back('{CMD_QUERY, t, rnd32(), rnd32()});
   endtask

   // Driver: presents one word at a time, random bursts of idle.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_valid && !req_ready_q)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               req_gap <= $urandom_range(1, 15);
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !hold_sender) begin
               req_word_type w;
               w = pending_words.pop_front();
               req_valid          <= 1'b1;
               req_cmd            <= w.cmd;
               req_point_time     <= w.key;
               req_point_altitude <= w.alt;
               req_point_accel    <= w.acc;
               expected_rsp.push_back(interpolate_step(w));
               n_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         // receiver stall bursts
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(1, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: compares each result word with the oldest expectation.
   always @(posedge clock) begin
      req_ready_q <= req_ready;
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               rsp_word_type e;
               e = expected_rsp.pop_front();
               if (rsp_altitude_out !== e.alt) begin
                  $error("altitude_out: expected %h, got %h", e.alt, rsp_altitude_out);
                  errors++;
               end
               if (rsp_accel_out !== e.acc) begin
                  $error("accel_out: expected %h, got %h", e.acc, rsp_accel_out);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  errors++;
               end
               if (e.status == ST_INTERIOR) n_interior++;
               n_checked++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_words.size() > 0 || expected_rsp.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   task automatic fill_table_random(int n, bit ascending);
      logic [31:0] t;
      t = $urandom_range(0, 1000);
      for (int i = 0; i < n; i++) begin
         if (ascending) t = t + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200000));
         else t = $urandom_range(0, 400000);
         push_load(t, rnd32(), rnd32());
      end
   endtask

   initial begin
      int sets;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, one point, clamps, zero width, extremes
      push_query(32'h0);
      push_query(32'hFFFF_FFFF);
      push_load(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      push_query(32'h0001_0000);            // one point: clamp low at equal key
      push_query(32'hFFFF_FFFF);
      push_load(32'h0001_0000, 32'h0, 32'h1); // zero-width pair
      push_load(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      push_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      push_query(32'h0001_0000);
      push_query(32'h0002_0000);
      push_query(32'h0002_8001);
      push_query(32'h0003_0000);
      push_query(32'h8000_0000);
      push_query(32'hFFFF_FFFE);
      push_query(32'hFFFF_FFFF);
      push_query(32'h0);
      wait_drained();

      // Pressure: hold the sender idle with all results already in, then continue.
      hold_sender = 1;
      repeat (20) @(posedge clock);
      hold_sender = 0;

      // A run of equal times appended after a descending step.
      for (int i = 0; i < 30; i++) push_load(32'h0000_0010, rnd32(), rnd32());
      push_query(32'h0000_0010);
      wait_drained();

      // Random phases: fresh table per phase needs reset, which is not allowed,
      // so a non-ascending tail is tested on top of this table instead.
      // The table keeps growing; keys come from 0..16, 0..3000000 or all 32 bits.
      sets = 0;
      while (n_sent < 430) begin
         fill_table_random($urandom_range(1, 6), $urandom_range(0, 4) != 0);
         repeat (12) begin
            case ($urandom_range(0, 5))
               0: push_query(rnd32());
               1: push_query($urandom_range(0, 16));
               2: push_load(rnd32(), rnd32(), rnd32());
               default: push_query($urandom_range(0, 3000000));
            endcase
         end
         wait_drained();
         sets++;
      end

      // Last part has no idling.
      calm = 1;
      for (int i = 0; i < 100; i++) begin
         if ($urandom_range(0, 2) == 0) push_load(rnd32(), rnd32(), rnd32());
         else push_query($urandom_range(0, 3000000));
      end
      wait_drained();
      repeat (200) @(posedge clock);
      $display("Run covered %0d request words over %0d table phases, %0d results checked,",
               n_sent, sets, n_checked);
      $display("%0d interior interpolations; table ended with %0d points.",
               n_interior, tbl_count);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end
endmodule
